// ===== rtl/core/i2cm_pkg.sv =====
package i2cm_pkg;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_BEGIN  = 2'd1,
		OP_SUPPLY = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_WRITE    = 2'd0,
		KIND_READ     = 2'd1,
		KIND_REG_WR   = 2'd2,
		KIND_REG_RD   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_START  = 4'd1,
		PH_WDEV   = 4'd2,
		PH_ADEV   = 4'd3,
		PH_WAHI   = 4'd4,
		PH_AAHI   = 4'd5,
		PH_WALO   = 4'd6,
		PH_AALO   = 4'd7,
		PH_RSTART = 4'd8,
		PH_WDEVR  = 4'd9,
		PH_ADEVR  = 4'd10,
		PH_WAITB  = 4'd11,
		PH_WDATA  = 4'd12,
		PH_ADATA  = 4'd13,
		PH_READ   = 4'd14,
		PH_STOP   = 4'd15
	} phase_t;

	localparam int RATE_BITS = 22;
	localparam logic [RATE_BITS-1:0] RATE_RESET = 22'd100000;
	localparam logic [RATE_BITS-1:0] RATE_STD   = 22'd100000;
	localparam logic [RATE_BITS-1:0] RATE_FAST  = 22'd200000;

	localparam logic [2:0] HALF_STD  = 3'd5;
	localparam logic [2:0] HALF_FAST = 3'd2;
	localparam logic [2:0] HALF_MAX  = 3'd1;

	localparam int        APB_ADDR_BITS = 3;
	localparam logic      REG_BUS_RATE  = 1'b0;

	localparam int IN_BITS  = 56;
	localparam int OUT_BITS = 16;

	typedef struct packed {
		logic scl;
		logic sda;
		logic rel;
	} lvl_t;

	typedef struct packed {
		logic       status;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       need_byte;
		logic       busy_res;
		logic       sda_released;
		logic       sda_out;
		logic       scl;
	} res_t;

	function automatic logic is_write_phase(phase_t p);
		return p == PH_WDEV || p == PH_WAHI || p == PH_WALO || p == PH_WDEVR || p == PH_WDATA;
	endfunction

	function automatic logic is_ack_phase(phase_t p);
		return p == PH_ADEV || p == PH_AAHI || p == PH_AALO || p == PH_ADEVR || p == PH_ADATA;
	endfunction

	function automatic lvl_t bus_levels(phase_t p, logic [2:0] sub, logic [2:0] bit_idx,
		logic msb, logic last_byte);
		lvl_t l;
		l.scl = 1'b1;
		l.sda = 1'b1;
		l.rel = 1'b0;
		if (p == PH_START || p == PH_RSTART) begin
			l.scl = sub < 3'd2;
			l.sda = sub == 3'd0;
		end else if (is_write_phase(p)) begin
			l.scl = sub == 3'd0;
			l.sda = (sub != 3'd0 && bit_idx == 3'd7) ? 1'b1 : msb;
		end else if (is_ack_phase(p)) begin
			l.scl = sub == 3'd1;
			l.rel = sub < 3'd2;
		end else if (p == PH_WAITB) begin
			l.scl = 1'b0;
		end else if (p == PH_READ) begin
			l.scl = sub == 3'd1 || sub == 3'd5;
			l.rel = sub < 3'd3;
			if (sub >= 3'd4) begin
				l.sda = last_byte;
			end
		end else if (p == PH_STOP) begin
			l.scl = sub >= 3'd2;
			l.sda = sub == 3'd0 || sub == 3'd3;
		end
		return l;
	endfunction

endpackage

// ===== rtl/core/i2c_master_transaction_engine.sv =====
// Channel     | Direction | Handshake                  | Content
// s_axis      | in        | s_axis_tvalid/s_axis_tready | op in tuser, transaction fields in tdata
// m_axis      | out       | m_axis_tvalid/m_axis_tready | bus levels, status and received byte
// apb         | in        | psel/penable/pready         | bus_rate_hz at byte address 0
//
// A request's state update and its result are computed in the cycle it is
// accepted, and the result is registered for the output side.
// A two-entry output buffer keeps requests flowing while one result waits.
// The input side stalls only when both output entries are full.
// Reset returns the engine to idle with SCL and SDA high and the rate at 100 kHz.
module i2c_master_transaction_engine #(
	parameter int LENGTH_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// kind[1:0], dev_addr[9:2], mem_addr[25:10], addr_two_bytes[26], length[42:27],
	// tx_byte[50:43], sda_in[51], zero fill[55:52]
	input  logic [i2cm_pkg::IN_BITS-1:0]        s_axis_tdata,
	// op[1:0]
	input  logic [1:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// scl[0], sda_out[1], sda_released[2], busy_res[3], need_byte[4], rx_valid[5],
	// rx_byte[13:6], done_res[14], status[15]
	output logic [i2cm_pkg::OUT_BITS-1:0]       m_axis_tdata,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [i2cm_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import i2cm_pkg::*;

	typedef struct packed {
		phase_t                 phase;
		logic [2:0]             sub;
		logic [2:0]             bit_idx;
		logic [7:0]             shreg;
		logic [2:0]             wait_cnt;
		logic [2:0]             half;
		logic [LENGTH_BITS-1:0] left;
		logic [1:0]             kind;
		logic [7:0]             dev;
		logic [15:0]            addr;
		logic                   wide;
		logic                   nack;
	} eng_t;

	function automatic eng_t enter(eng_t s, phase_t p);
		eng_t r;
		r          = s;
		r.phase    = p;
		r.sub      = 3'd0;
		r.bit_idx  = 3'd0;
		r.wait_cnt = 3'd0;
		return r;
	endfunction

	localparam logic [LENGTH_BITS-1:0] LEFT_ONE = LENGTH_BITS'(1);

	logic [RATE_BITS-1:0] rate_q;
	eng_t                 eng_q;
	eng_t                 eng_nx;
	res_t                 res;
	res_t                 out_q;
	res_t                 skid_q;
	logic                 out_vld_q;
	logic                 skid_vld_q;
	logic                 accept;
	lvl_t                 lvl;

	op_t                    in_op;
	logic [1:0]             in_kind;
	logic [7:0]             in_dev;
	logic [15:0]            in_addr;
	logic                   in_wide;
	logic [LENGTH_BITS-1:0] in_len;
	logic [7:0]             in_tx;
	logic                   in_sda;

	assign in_op   = op_t'(s_axis_tuser);
	assign in_kind = s_axis_tdata[1:0];
	assign in_dev  = s_axis_tdata[9:2];
	assign in_addr = s_axis_tdata[25:10];
	assign in_wide = s_axis_tdata[26];
	assign in_len  = s_axis_tdata[27 +: LENGTH_BITS];
	assign in_tx   = s_axis_tdata[50:43];
	assign in_sda  = s_axis_tdata[51];

	assign s_axis_tready = !skid_vld_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BUS_RATE) ? {{(32-RATE_BITS){1'b0}}, rate_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_BUS_RATE) begin
			rate_q <= pwdata[RATE_BITS-1:0];
		end
	end

	always_comb begin
		logic [LENGTH_BITS-1:0] left_dec;
		logic [7:0]             shifted;
		eng_nx           = eng_q;
		res              = '0;
		left_dec         = (eng_q.left != '0) ? eng_q.left - LEFT_ONE : eng_q.left;
		shifted          = {eng_q.shreg[6:0], in_sda};
		unique case (in_op)
			OP_TICK: begin
				if (eng_q.phase != PH_IDLE && eng_q.phase != PH_WAITB) begin
					eng_nx.wait_cnt = eng_q.wait_cnt + 3'd1;
					if (eng_nx.wait_cnt >= eng_q.half) begin
						eng_nx.wait_cnt = 3'd0;
						if (eng_q.phase == PH_START || eng_q.phase == PH_RSTART) begin
							if (eng_q.sub < 3'd2) begin
								eng_nx.sub = eng_q.sub + 3'd1;
							end else begin
								eng_nx = enter(eng_q, phase_t'(eng_q.phase + 4'd1));
							end
						end else if (is_write_phase(eng_q.phase)) begin
							if (eng_q.sub == 3'd0) begin
								eng_nx.sub = 3'd1;
							end else begin
								eng_nx.shreg = {eng_q.shreg[6:0], 1'b0};
								if (eng_q.bit_idx == 3'd7) begin
									eng_nx = enter(eng_nx, phase_t'(eng_q.phase + 4'd1));
								end else begin
									eng_nx.bit_idx = eng_q.bit_idx + 3'd1;
									eng_nx.sub     = 3'd0;
								end
							end
						end else if (is_ack_phase(eng_q.phase)) begin
							if (eng_q.sub == 3'd0) begin
								eng_nx.sub = 3'd1;
							end else if (eng_q.sub == 3'd1) begin
								if (in_sda) begin
									eng_nx.nack = 1'b1;
								end
								eng_nx.sub = 3'd2;
							end else if (eng_q.nack) begin
								eng_nx = enter(eng_q, PH_STOP);
							end else begin
								unique case (eng_q.phase)
									PH_ADEV: begin
										if (eng_q.kind == KIND_WRITE) begin
											eng_nx = enter(eng_q,
												(eng_q.left == '0) ? PH_STOP : PH_WAITB);
										end else if (eng_q.kind == KIND_READ) begin
											eng_nx       = enter(eng_q, PH_READ);
											eng_nx.shreg = 8'd0;
										end else if (eng_q.wide) begin
											eng_nx       = enter(eng_q, PH_WAHI);
											eng_nx.shreg = eng_q.addr[15:8];
										end else begin
											eng_nx       = enter(eng_q, PH_WALO);
											eng_nx.shreg = eng_q.addr[7:0];
										end
									end
									PH_AAHI: begin
										eng_nx       = enter(eng_q, PH_WALO);
										eng_nx.shreg = eng_q.addr[7:0];
									end
									PH_AALO: begin
										if (eng_q.kind == KIND_REG_WR) begin
											eng_nx = enter(eng_q,
												(eng_q.left == '0) ? PH_STOP : PH_WAITB);
										end else begin
											eng_nx       = enter(eng_q, PH_RSTART);
											eng_nx.shreg = eng_q.dev | 8'h01;
										end
									end
									PH_ADEVR: begin
										eng_nx       = enter(eng_q, PH_READ);
										eng_nx.shreg = 8'd0;
									end
									default: begin
										eng_nx      = enter(eng_q,
											(left_dec == '0) ? PH_STOP : PH_WAITB);
										eng_nx.left = left_dec;
									end
								endcase
							end
						end else if (eng_q.phase == PH_READ) begin
							if (eng_q.sub == 3'd1) begin
								eng_nx.shreg = shifted;
								if (eng_q.bit_idx == 3'd7) begin
									res.rx_valid = 1'b1;
									res.rx_byte  = shifted;
								end
								eng_nx.sub = 3'd2;
							end else if (eng_q.sub == 3'd2) begin
								if (eng_q.bit_idx == 3'd7) begin
									eng_nx.sub = 3'd3;
								end else begin
									eng_nx.bit_idx = eng_q.bit_idx + 3'd1;
									eng_nx.sub     = 3'd1;
								end
							end else if (eng_q.sub < 3'd6) begin
								eng_nx.sub = eng_q.sub + 3'd1;
							end else if (eng_q.left <= LEFT_ONE) begin
								eng_nx = enter(eng_q, PH_STOP);
							end else begin
								eng_nx       = enter(eng_q, PH_READ);
								eng_nx.left  = left_dec;
								eng_nx.shreg = 8'd0;
							end
						end else if (eng_q.phase == PH_STOP) begin
							if (eng_q.sub < 3'd3) begin
								eng_nx.sub = eng_q.sub + 3'd1;
							end else begin
								res.done_res = 1'b1;
								eng_nx       = enter(eng_q, PH_IDLE);
							end
						end else begin
							eng_nx = enter(eng_q, PH_IDLE);
						end
					end
				end
			end
			OP_BEGIN: begin
				if (eng_q.phase == PH_IDLE) begin
					eng_nx       = enter(eng_q, PH_START);
					eng_nx.kind  = in_kind;
					eng_nx.dev   = in_dev;
					eng_nx.addr  = in_addr;
					eng_nx.wide  = in_wide;
					eng_nx.nack  = 1'b0;
					if ((in_kind == KIND_READ || in_kind == KIND_REG_RD) && in_len == '0) begin
						eng_nx.left = LEFT_ONE;
					end else begin
						eng_nx.left = in_len;
					end
					if (rate_q <= RATE_STD) begin
						eng_nx.half = HALF_STD;
					end else if (rate_q <= RATE_FAST) begin
						eng_nx.half = HALF_FAST;
					end else begin
						eng_nx.half = HALF_MAX;
					end
					eng_nx.shreg = (in_kind == KIND_READ) ? (in_dev | 8'h01) : in_dev;
				end
			end
			OP_SUPPLY: begin
				if (eng_q.phase == PH_WAITB) begin
					eng_nx       = enter(eng_q, PH_WDATA);
					eng_nx.shreg = in_tx;
				end
			end
			default: begin
				eng_nx = eng_q;
			end
		endcase

		if (in_op == OP_TICK) begin
			lvl = bus_levels(eng_q.phase, eng_q.sub, eng_q.bit_idx, eng_q.shreg[7],
				eng_q.left <= LEFT_ONE);
		end else begin
			lvl = bus_levels(eng_nx.phase, eng_nx.sub, eng_nx.bit_idx, eng_nx.shreg[7],
				eng_nx.left <= LEFT_ONE);
		end
		res.scl          = lvl.scl;
		res.sda_out      = lvl.sda;
		res.sda_released = lvl.rel;
		res.busy_res     = eng_nx.phase != PH_IDLE;
		res.need_byte    = eng_nx.phase == PH_WAITB;
		res.status       = res.done_res && eng_nx.nack;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_q          <= '0;
			eng_q.phase    <= PH_IDLE;
			eng_q.half     <= HALF_STD;
		end else if (accept) begin
			eng_q <= eng_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || m_axis_tready) begin
				if (skid_vld_q) begin
					out_vld_q  <= 1'b1;
					skid_vld_q <= 1'b0;
				end else begin
					out_vld_q <= accept;
				end
			end else if (accept) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_axis_tready) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

endmodule

// ===== rtl/core/i2cm_checker.sv =====
module i2cm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// A result that is not taken keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output changed while stalled");

	// A finished transaction leaves the engine idle, and error status only comes with it.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[14] || m_axis_tdata[15]) |->
		m_axis_tdata[14] && !m_axis_tdata[3])
		else $error("done or status inconsistent with busy");

	// While a write byte is awaited the bus is held with SCL low.
	a_wait: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3] && !m_axis_tdata[0])
		else $error("waiting for a byte without holding the bus");

	// A released SDA reads back as high.
	a_rel: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
		else $error("released SDA driven low");

	// No received byte shows without its valid flag.
	a_rx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[5] |-> m_axis_tdata[13:6] == 8'd0)
		else $error("received byte without valid");

endmodule

bind i2c_master_transaction_engine i2cm_checker u_i2cm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
